### hdl/qbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbb_pkg
// Shared widths, operation codes and register indexes of the quadrant binner.
// ----------------------------------------------------------------------------
package qbb_pkg;

    // Field widths of the command and result transfers
    localparam int FUNC_W   = 2;
    localparam int SHAPE_W  = 8;
    localparam int POS_W    = 16;
    localparam int RADIUS_W = 14;
    localparam int HALF_W   = 15;
    localparam int QUADS    = 4;
    localparam int QUAD_W   = 2;
    localparam int CFG_IDX_W = 1;

    // Wide enough to hold any supported id width before selecting bits
    localparam int ID_EXT_W = 16;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RETRIEVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 1'd1;

    localparam logic [HALF_W-1:0] HALF_RESET = 15'd1600;

    typedef logic [QUADS-1:0] t_quad_mask;

endpackage

### hdl/qbb_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbb_cmd_if
// Command channel of the quadrant binner: valid/ready with operation payload.
// ----------------------------------------------------------------------------
interface qbb_cmd_if;

    logic                               valid;
    logic                               ready;
    logic [qbb_pkg::FUNC_W-1:0]         func;
    logic [qbb_pkg::SHAPE_W-1:0]        shape_id;
    logic signed [qbb_pkg::POS_W-1:0]   pos_x;
    logic signed [qbb_pkg::POS_W-1:0]   pos_y;
    logic [qbb_pkg::RADIUS_W-1:0]       radius;

    modport source (
        output valid, func, shape_id, pos_x, pos_y, radius,
        input  ready
    );

    modport sink (
        input  valid, func, shape_id, pos_x, pos_y, radius,
        output ready
    );

endinterface

### hdl/qbb_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbb_res_if
// Result channel of the quadrant binner: valid/ready with candidate payload.
// ----------------------------------------------------------------------------
interface qbb_res_if;

    logic                           valid;
    logic                           ready;
    logic [qbb_pkg::SHAPE_W-1:0]    cand_id;
    qbb_pkg::t_quad_mask            quad_mask;
    logic                           overflow;
    logic                           last;

    modport source (
        output valid, cand_id, quad_mask, overflow, last,
        input  ready
    );

    modport sink (
        input  valid, cand_id, quad_mask, overflow, last,
        output ready
    );

endinterface

### hdl/qbb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module qbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

### hdl/quadrant_broadphase_binner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrant_broadphase_binner
// Broad-phase binner: four quadrant id lists in one RAM, insert/retrieve/clear.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one operation per transfer (insert, retrieve, clear); o_res
//   returns its results, the final one flagged by last. Half sizes are set
//   through the write port (i_cfg_we, i_cfg_idx, i_cfg_data); the user must
//   set them only while idle, which the block does not enforce. One command is
//   worked at a time; i_cmd.ready is high only when idle. Insert: the four
//   quadrants are visited one per cycle, writing the id into the list RAM.
//   Clear and unused codes go directly to the result state. Retrieve: a scan
//   reads every stored slot, one RAM read per cycle, and passes an empty list
//   without a read; the query id follows the last compare. The candidates
//   then stream at one per cycle while the receiver takes them, with a pass
//   through ST_EMIT_RD per quadrant looked at; copies of the query id are
//   skipped. The single RAM read port sets this rate. Results sit in an
//   output register; a new command can be taken while the last result still
//   waits. A stalled receiver freezes the candidate walk. Reset clears all
//   list counts and sets both half sizes to 1600 (100.0). Slots beyond a
//   list's count are never read, so the RAM needs no clearing.
// ----------------------------------------------------------------------------
module quadrant_broadphase_binner #(
    parameter int MAX_PER_QUADRANT = 16,
    parameter int ID_BITS          = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    qbb_cmd_if.sink                         i_cmd,
    qbb_res_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [qbb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [qbb_pkg::HALF_W-1:0]      i_cfg_data
);

    localparam int SLOT_W = $clog2(MAX_PER_QUADRANT);
    localparam int CNT_W  = SLOT_W + 1;
    localparam int ADDR_W = qbb_pkg::QUAD_W + SLOT_W;
    localparam int DEPTH  = qbb_pkg::QUADS << SLOT_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PER_QUADRANT);

    // Sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_INS     = 3'd1;
    localparam logic [2:0] ST_SCAN    = 3'd2;
    localparam logic [2:0] ST_RESP    = 3'd3;
    localparam logic [2:0] ST_EMIT_RD = 3'd4;
    localparam logic [2:0] ST_EMIT_WT = 3'd5;

    logic [2:0]                       r_state;
    logic [qbb_pkg::HALF_W-1:0]       r_half_w;
    logic [qbb_pkg::HALF_W-1:0]       r_half_h;
    logic [CNT_W-1:0]                 r_cnt [qbb_pkg::QUADS];
    logic [qbb_pkg::FUNC_W-1:0]       r_func;
    logic [ID_BITS-1:0]               r_id;
    logic signed [qbb_pkg::POS_W-1:0] r_pos_x;
    logic signed [qbb_pkg::POS_W-1:0] r_pos_y;
    logic [qbb_pkg::RADIUS_W-1:0]     r_radius;
    logic [qbb_pkg::QUAD_W-1:0]       r_q;
    logic [SLOT_W-1:0]                r_i;
    logic                             r_walk_done;
    qbb_pkg::t_quad_mask              r_mask;
    logic                             r_ovf;
    logic                             r_cmp_v;
    logic [qbb_pkg::QUAD_W-1:0]       r_cmp_q;
    logic [SLOT_W-1:0]                r_cmp_i;
    qbb_pkg::t_quad_mask              r_found;
    qbb_pkg::t_quad_mask              r_has_other;
    logic [SLOT_W-1:0]                r_last_oth [qbb_pkg::QUADS];

    logic                             r_out_valid;
    logic [qbb_pkg::SHAPE_W-1:0]      r_out_id;
    qbb_pkg::t_quad_mask              r_out_mask;
    logic                             r_out_ovf;
    logic                             r_out_last;

    // RAM port signals
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic                   ram_re;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [ID_BITS-1:0]     ram_rdata;

    logic [qbb_pkg::ID_EXT_W-1:0] shape_ext;
    logic [qbb_pkg::ID_EXT_W-1:0] rd_ext;
    logic [qbb_pkg::ID_EXT_W-1:0] qid_ext;
    logic                   cmd_xfer;
    logic                   out_free;
    logic [CNT_W-1:0]       cur_cnt;
    logic                   cur_full;
    logic                   scan_issue;
    logic                   scan_end_q;
    qbb_pkg::t_quad_mask    act;
    logic                   later_act;
    logic                   emit_end_q;
    logic                   emit_last;
    logic                   rd_is_query;

    logic signed [17:0]     x18;
    logic signed [17:0]     y18;
    logic signed [17:0]     m18;
    logic signed [17:0]     sx;
    logic signed [17:0]     sy;
    logic                   east_x;
    logic                   west_x;
    logic                   north_y;
    logic                   south_y;
    qbb_pkg::t_quad_mask    hit;

    assign cmd_xfer    = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || o_res.ready;

    // Id width adaptation between the 8-bit fields and the stored ids
    assign shape_ext = qbb_pkg::ID_EXT_W'(i_cmd.shape_id);
    assign rd_ext    = qbb_pkg::ID_EXT_W'(ram_rdata);
    assign qid_ext   = qbb_pkg::ID_EXT_W'(r_id);

    assign cur_cnt  = r_cnt[r_q];
    assign cur_full = (cur_cnt >= MAX_CNT);

    // Quadrant box test, bounds inclusive and widened by twice the radius
    assign x18 = 18'(r_pos_x);
    assign y18 = 18'(r_pos_y);
    assign m18 = signed'({3'b000, r_radius, 1'b0});
    assign sx  = signed'({3'b000, r_half_w}) + m18;
    assign sy  = signed'({3'b000, r_half_h}) + m18;
    assign east_x  = (x18 >= -m18) && (x18 <= sx);
    assign west_x  = (x18 >= -sx)  && (x18 <= m18);
    assign north_y = (y18 >= -m18) && (y18 <= sy);
    assign south_y = (y18 >= -sy)  && (y18 <= m18);
    assign hit = {east_x && south_y, west_x && south_y, east_x && north_y, west_x && north_y};

    // Scan walk: issue a read while the current slot lies below the count
    assign scan_issue = (r_state == ST_SCAN) && !r_walk_done && ({1'b0, r_i} < cur_cnt);
    assign scan_end_q = ({1'b0, r_i} + CNT_W'(1) >= cur_cnt);

    // Candidate walk bookkeeping
    assign act         = r_found & r_has_other;
    assign later_act   = |(act & qbb_pkg::t_quad_mask'(4'b1110 << r_q));
    assign emit_end_q  = (r_i == r_last_oth[r_q]);
    assign emit_last   = emit_end_q && !later_act;
    assign rd_is_query = (ram_rdata == r_id);

    // RAM access selection
    always_comb begin
        ram_we    = (r_state == ST_INS) && hit[r_q] && !cur_full;
        ram_waddr = {r_q, cur_cnt[SLOT_W-1:0]};
        ram_re    = 1'b0;
        ram_raddr = {r_q, r_i};
        case (r_state)
            ST_SCAN: begin
                ram_re = scan_issue;
            end
            ST_EMIT_RD: begin
                ram_re = act[r_q];
            end
            ST_EMIT_WT: begin
                ram_raddr = {r_q, r_i + SLOT_W'(1)};
                ram_re    = !emit_end_q && (rd_is_query || out_free);
            end
            default: begin
                ram_re = 1'b0;
            end
        endcase
    end

    qbb_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (DEPTH)
    ) u_ids (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_id),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_w <= qbb_pkg::HALF_RESET;
            r_half_h <= qbb_pkg::HALF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qbb_pkg::CFG_HALF_WIDTH:  r_half_w <= i_cfg_data;
                qbb_pkg::CFG_HALF_HEIGHT: r_half_h <= i_cfg_data;
                default: begin
                    r_half_w <= r_half_w;
                end
            endcase
        end
    end

    // Capture the command payload on transfer
    always_ff @(posedge i_clk) begin
        if (cmd_xfer) begin
            r_func   <= i_cmd.func;
            r_id     <= shape_ext[ID_BITS-1:0];
            r_pos_x  <= i_cmd.pos_x;
            r_pos_y  <= i_cmd.pos_y;
            r_radius <= i_cmd.radius;
        end
    end

    // Scan compare stage: works on the read data in the cycle after the RAM read
    always_ff @(posedge i_clk) begin
        r_cmp_q <= r_q;
        r_cmp_i <= r_i;
        if (cmd_xfer) begin
            r_found     <= '0;
            r_has_other <= '0;
        end else if (r_cmp_v) begin
            if (rd_is_query) begin
                r_found[r_cmp_q] <= 1'b1;
            end else begin
                r_has_other[r_cmp_q] <= 1'b1;
                r_last_oth[r_cmp_q]  <= r_cmp_i;
            end
        end
    end

    // Sequencer and list counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cmp_v     <= 1'b0;
            r_walk_done <= 1'b0;
            for (int q = 0; q < qbb_pkg::QUADS; q++) begin
                r_cnt[q] <= '0;
            end
        end else begin
            r_cmp_v <= scan_issue;
            case (r_state)
                ST_IDLE: begin
                    if (cmd_xfer) begin
                        r_q         <= '0;
                        r_i         <= '0;
                        r_walk_done <= 1'b0;
                        r_mask      <= '0;
                        r_ovf       <= 1'b0;
                        case (i_cmd.func)
                            qbb_pkg::FUNC_INSERT:   r_state <= ST_INS;
                            qbb_pkg::FUNC_RETRIEVE: r_state <= ST_SCAN;
                            qbb_pkg::FUNC_CLEAR: begin
                                for (int q = 0; q < qbb_pkg::QUADS; q++) begin
                                    r_cnt[q] <= '0;
                                end
                                r_state <= ST_RESP;
                            end
                            default: r_state <= ST_RESP;
                        endcase
                    end
                end
                ST_INS: begin
                    // Visit one quadrant per cycle, append or flag overflow
                    if (hit[r_q]) begin
                        if (cur_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_cnt[r_q]  <= cur_cnt + CNT_W'(1);
                            r_mask[r_q] <= 1'b1;
                        end
                    end
                    r_q <= r_q + qbb_pkg::QUAD_W'(1);
                    if (r_q == qbb_pkg::QUAD_W'(qbb_pkg::QUADS - 1)) begin
                        r_state <= ST_RESP;
                    end
                end
                ST_SCAN: begin
                    if (!r_walk_done) begin
                        // Advance slot, or move to the next quadrant
                        if (scan_end_q) begin
                            r_i <= '0;
                            r_q <= r_q + qbb_pkg::QUAD_W'(1);
                            if (r_q == qbb_pkg::QUAD_W'(qbb_pkg::QUADS - 1)) begin
                                r_walk_done <= 1'b1;
                            end
                        end else begin
                            r_i <= r_i + SLOT_W'(1);
                        end
                    end else if (!r_cmp_v) begin
                        r_state <= ST_RESP;
                    end
                end
                ST_RESP: begin
                    if (out_free) begin
                        r_q <= '0;
                        r_i <= '0;
                        if (r_func == qbb_pkg::FUNC_RETRIEVE && act != '0) begin
                            r_state <= ST_EMIT_RD;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_EMIT_RD: begin
                    if (act[r_q]) begin
                        r_state <= ST_EMIT_WT;
                    end else begin
                        r_q <= r_q + qbb_pkg::QUAD_W'(1);
                    end
                end
                ST_EMIT_WT: begin
                    // Skip copies of the query id, hold while the output is full
                    if (rd_is_query || out_free) begin
                        if (emit_end_q) begin
                            r_i <= '0;
                            r_q <= r_q + qbb_pkg::QUAD_W'(1);
                            r_state <= emit_last ? ST_IDLE : ST_EMIT_RD;
                        end else begin
                            r_i <= r_i + SLOT_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Output register: load a result, drop it once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_RESP && out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_state == ST_EMIT_WT && out_free && !rd_is_query) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RESP && out_free) begin
            r_out_id   <= qid_ext[qbb_pkg::SHAPE_W-1:0];
            r_out_mask <= (r_func == qbb_pkg::FUNC_INSERT) ? r_mask : '0;
            r_out_ovf  <= (r_func == qbb_pkg::FUNC_INSERT) && r_ovf;
            r_out_last <= (r_func != qbb_pkg::FUNC_RETRIEVE) || (act == '0);
        end else if (r_state == ST_EMIT_WT && out_free && !rd_is_query) begin
            r_out_id   <= rd_ext[qbb_pkg::SHAPE_W-1:0];
            r_out_mask <= qbb_pkg::t_quad_mask'(4'b0001 << r_q);
            r_out_ovf  <= 1'b0;
            r_out_last <= emit_last;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.cand_id   = r_out_id;
    assign o_res.quad_mask = r_out_mask;
    assign o_res.overflow  = r_out_ovf;
    assign o_res.last      = r_out_last;

endmodule

### verif/tb_quadrant_broadphase_binner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadrant_broadphase_binner
// Self-checking bench for the quadrant binner. A directed table covers the
// field extremes, every operation, a full quadrant and the largest retrieve.
// Random phases follow under several half-size settings. A predictor holds
// its own copy of the quadrant lists and scores every result transfer.
// ----------------------------------------------------------------------------
module tb_quadrant_broadphase_binner;

    localparam int MAX_PER_QUAD    = 16;
    localparam int ITEMS_PER_PHASE = 58;
    localparam int PHASES          = 6;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int MAX_REPORTS     = 20;
    localparam int RECENT_DEPTH    = 24;

    // Short names for the operation codes in the directed table
    localparam logic [qbb_pkg::FUNC_W-1:0] OP_INS = qbb_pkg::FUNC_INSERT;
    localparam logic [qbb_pkg::FUNC_W-1:0] OP_RET = qbb_pkg::FUNC_RETRIEVE;
    localparam logic [qbb_pkg::FUNC_W-1:0] OP_CLR = qbb_pkg::FUNC_CLEAR;

    // Code the block does not use; it only echoes the id
    localparam logic [qbb_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

    typedef struct {
        logic [qbb_pkg::FUNC_W-1:0]          func;
        logic [qbb_pkg::SHAPE_W-1:0]         shape_id;
        logic signed [qbb_pkg::POS_W-1:0]    pos_x;
        logic signed [qbb_pkg::POS_W-1:0]    pos_y;
        logic [qbb_pkg::RADIUS_W-1:0]        radius;
    } t_bin_cmd;

    typedef struct {
        logic [qbb_pkg::SHAPE_W-1:0] cand_id;
        qbb_pkg::t_quad_mask         quad_mask;
        logic                        overflow;
        logic                        last;
    } t_cand;

    typedef struct {
        logic [qbb_pkg::FUNC_W-1:0]          func;
        logic [qbb_pkg::SHAPE_W-1:0]         id;
        logic signed [qbb_pkg::POS_W-1:0]    x;
        logic signed [qbb_pkg::POS_W-1:0]    y;
        logic [qbb_pkg::RADIUS_W-1:0]        r;
        int                                  reps;
        bit                                  typed;
        logic [qbb_pkg::SHAPE_W-1:0]         w_id;
        qbb_pkg::t_quad_mask                 w_mask;
        logic                                w_ovf;
    } t_plan_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [qbb_pkg::CFG_IDX_W-1:0]   i_cfg_idx;
    logic [qbb_pkg::HALF_W-1:0]      i_cfg_data;

    qbb_cmd_if cmd_ch ();
    qbb_res_if res_ch ();

    quadrant_broadphase_binner #(
        .MAX_PER_QUADRANT (MAX_PER_QUAD),
        .ID_BITS          (qbb_pkg::SHAPE_W)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state: field size and the four quadrant lists
    int                          half_w = 1600;
    int                          half_h = 1600;
    logic [qbb_pkg::SHAPE_W-1:0] bin_ids [qbb_pkg::QUADS][MAX_PER_QUAD];
    int                          bin_count [qbb_pkg::QUADS];

    t_cand                       expected_cands [$];
    logic [qbb_pkg::SHAPE_W-1:0] recent_ids [$];

    int  cmds_sent      = 0;
    int  cands_checked  = 0;
    int  overflows_seen = 0;
    int  settings_used  = 1;
    int  fail_count     = 0;
    int  cycle_count    = 0;
    bit  cmd_calm       = 1'b0;
    bit  res_calm       = 1'b0;

    // Directed stimulus; typed rows carry the one result read straight off
    t_plan_row dir_plan [17] = '{
        // retrieve on empty lists: query id alone
        '{OP_RET,     8'h55, 16'sh0000, 16'sh0000, 14'h0000, 1, 1, 8'h55, 4'h0, 1'b0},
        // origin sits on all four boxes
        '{OP_INS,     8'h00, 16'sh0000, 16'sh0000, 14'h0000, 1, 1, 8'h00, 4'hF, 1'b0},
        // far corner lies outside every box
        '{OP_INS,     8'hFF, 16'sh7FFF, 16'sh7FFF, 14'h0000, 1, 1, 8'hFF, 4'h0, 1'b0},
        // most negative centre, widest margin: south-west only
        '{OP_INS,     8'hAA, 16'sh8000, 16'sh8000, 14'h3FFF, 1, 1, 8'hAA, 4'h4, 1'b0},
        '{OP_INS,     8'h11, 16'sh0320, 16'sh0320, 14'h0000, 1, 0, 8'h00, 4'h0, 1'b0},
        '{OP_INS,     8'h22, -16'sh0320, 16'sh0320, 14'h01F4, 1, 0, 8'h00, 4'h0, 1'b0},
        '{OP_INS,     8'h33, -16'sh0320, -16'sh0320, 14'h0000, 1, 0, 8'h00, 4'h0, 1'b0},
        // corner of the south-east box, bounds inclusive
        '{OP_INS,     8'h44, 16'sh0640, -16'sh0640, 14'h0000, 1, 0, 8'h00, 4'h0, 1'b0},
        '{OP_RET,     8'h00, 16'sh0000, 16'sh0000, 14'h0000, 1, 0, 8'h00, 4'h0, 1'b0},
        '{OP_RET,     8'h22, 16'sh0000, 16'sh0000, 14'h0000, 1, 0, 8'h00, 4'h0, 1'b0},
        // unused code with every position and radius bit set
        '{FUNC_SPARE, 8'h7E, 16'shFFFF, 16'shFFFF, 14'h3FFF, 1, 1, 8'h7E, 4'h0, 1'b0},
        '{OP_CLR,     8'h5A, 16'sh0000, 16'sh0000, 14'h0000, 1, 1, 8'h5A, 4'h0, 1'b0},
        '{OP_RET,     8'h00, 16'sh0000, 16'sh0000, 14'h0000, 1, 1, 8'h00, 4'h0, 1'b0},
        // fill every quadrant to the brim
        '{OP_INS,     8'h80, 16'sh0000, 16'sh0000, 14'h0000, 16, 0, 8'h00, 4'h0, 1'b0},
        // all four full: nothing stored, overflow raised
        '{OP_INS,     8'hC0, 16'sh0000, 16'sh0000, 14'h0000, 1, 1, 8'hC0, 4'h0, 1'b1},
        // query in all four full lists: longest burst
        '{OP_RET,     8'h80, 16'sh0000, 16'sh0000, 14'h0000, 1, 0, 8'h00, 4'h0, 1'b0},
        '{OP_CLR,     8'h00, 16'sh0000, 16'sh0000, 14'h0000, 1, 1, 8'h00, 4'h0, 1'b0}
    };

    // Work out the results of one command and advance the quadrant lists
    function automatic void predict_bins(input t_bin_cmd c);
        int                  px;
        int                  py;
        int                  margin;
        int                  lo_x;
        int                  lo_y;
        bit                  found;
        qbb_pkg::t_quad_mask mask;
        logic                ovf;
        t_cand               r;
        px     = int'(c.pos_x);
        py     = int'(c.pos_y);
        margin = 2 * int'({1'b0, c.radius});
        mask   = '0;
        ovf    = 1'b0;
        case (c.func)
            qbb_pkg::FUNC_INSERT: begin
                for (int q = 0; q < qbb_pkg::QUADS; q++) begin
                    lo_x = (q & 1) ? 0 : -half_w;
                    lo_y = (q & 2) ? -half_h : 0;
                    if (px >= lo_x - margin && px <= lo_x + half_w + margin &&
                        py >= lo_y - margin && py <= lo_y + half_h + margin) begin
                        if (bin_count[q] >= MAX_PER_QUAD) begin
                            ovf = 1'b1;
                        end else begin
                            bin_ids[q][bin_count[q]] = c.shape_id;
                            bin_count[q]++;
                            mask[q] = 1'b1;
                        end
                    end
                end
                r = '{cand_id: c.shape_id, quad_mask: mask, overflow: ovf, last: 1'b1};
                expected_cands.insert(expected_cands.size(), r);
            end
            qbb_pkg::FUNC_RETRIEVE: begin
                r = '{cand_id: c.shape_id, quad_mask: '0, overflow: 1'b0, last: 1'b0};
                expected_cands.insert(expected_cands.size(), r);
                for (int q = 0; q < qbb_pkg::QUADS; q++) begin
                    found = 1'b0;
                    for (int i = 0; i < bin_count[q]; i++)
                        if (bin_ids[q][i] == c.shape_id) found = 1'b1;
                    if (found) begin
                        for (int i = 0; i < bin_count[q]; i++) begin
                            if (bin_ids[q][i] != c.shape_id) begin
                                mask    = '0;
                                mask[q] = 1'b1;
                                r = '{cand_id: bin_ids[q][i], quad_mask: mask,
                                      overflow: 1'b0, last: 1'b0};
                                expected_cands.insert(expected_cands.size(), r);
                            end
                        end
                    end
                end
                expected_cands[expected_cands.size()-1].last = 1'b1;
            end
            default: begin
                if (c.func == qbb_pkg::FUNC_CLEAR) begin
                    for (int q = 0; q < qbb_pkg::QUADS; q++) bin_count[q] = 0;
                end
                r = '{cand_id: c.shape_id, quad_mask: '0, overflow: 1'b0, last: 1'b1};
                expected_cands.insert(expected_cands.size(), r);
            end
        endcase
    endfunction

    // Coordinate mostly in or near the field, sometimes on an axis or anywhere
    function automatic int pick_coord(input int half);
        int                               v;
        int                               lim;
        logic signed [qbb_pkg::POS_W-1:0] raw;
        case ($urandom_range(0, 9))
            6, 7:    v = int'($urandom_range(0, 128)) - 64;
            8, 9: begin
                raw = qbb_pkg::POS_W'($urandom);
                v   = int'(raw);
            end
            default: begin
                lim = half + half / 4 + 1;
                v   = int'($urandom_range(0, 2 * lim)) - lim;
            end
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    // Drive one command after a random gap and predict its results on transfer
    task automatic send_cmd(input t_bin_cmd c, input bit typed, input t_cand want);
        int gap;
        int n0;
        gap = cmd_calm ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 29) == 0) cmd_calm = !cmd_calm;
        repeat (gap) begin
            @(negedge i_clk);
            cmd_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        cmd_ch.valid    <= 1'b1;
        cmd_ch.func     <= c.func;
        cmd_ch.shape_id <= c.shape_id;
        cmd_ch.pos_x    <= c.pos_x;
        cmd_ch.pos_y    <= c.pos_y;
        cmd_ch.radius   <= c.radius;
        do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
        n0 = expected_cands.size();
        predict_bins(c);
        // Typed rows replace the prediction, the lists still advance
        if (typed) begin
            while (expected_cands.size() > n0) void'(expected_cands.pop_back());
            expected_cands.insert(expected_cands.size(), want);
        end
        cmds_sent++;
    endtask

    // Drain, then set both half sizes while the block is idle
    task automatic set_field(input int hw, input int hh);
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (expected_cands.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= qbb_pkg::CFG_HALF_WIDTH;
        i_cfg_data <= hw[qbb_pkg::HALF_W-1:0];
        @(negedge i_clk);
        i_cfg_idx  <= qbb_pkg::CFG_HALF_HEIGHT;
        i_cfg_data <= hh[qbb_pkg::HALF_W-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        half_w = hw;
        half_h = hh;
        settings_used++;
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("quadrant_broadphase_binner regression: fail");
        $finish;
    end

    // Result side: random stalls, score each transfer against the oldest expectation
    initial begin
        int    stall;
        t_cand want;
        res_ch.ready = 1'b0;
        forever begin
            stall = res_calm ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 29) == 0) res_calm = !res_calm;
            repeat (stall) begin
                @(negedge i_clk);
                res_ch.ready <= 1'b0;
            end
            @(negedge i_clk);
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
            cands_checked++;
            if (res_ch.overflow === 1'b1) overflows_seen++;
            if (expected_cands.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected result id=%0h mask=%0h ovf=%0b last=%0b",
                             $time, res_ch.cand_id, res_ch.quad_mask, res_ch.overflow,
                             res_ch.last);
            end else begin
                want = expected_cands.pop_front();
                if (res_ch.cand_id !== want.cand_id || res_ch.quad_mask !== want.quad_mask ||
                    res_ch.overflow !== want.overflow || res_ch.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: mismatch expected id=%0h mask=%0h ovf=%0b last=%0b, %s",
                                 $time, want.cand_id, want.quad_mask, want.overflow, want.last,
                                 $sformatf("actual id=%0h mask=%0h ovf=%0b last=%0b",
                                           res_ch.cand_id, res_ch.quad_mask,
                                           res_ch.overflow, res_ch.last));
                end
            end
        end
    end

    // Command side and run control
    initial begin
        t_bin_cmd c;
        t_cand    want;
        int       hw;
        int       hh;
        int       pick;
        int       rmax;
        int       cfg_w [PHASES];
        int       cfg_h [PHASES];

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = qbb_pkg::CFG_HALF_WIDTH;
        i_cfg_data      = '0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.func     = qbb_pkg::FUNC_INSERT;
        cmd_ch.shape_id = '0;
        cmd_ch.pos_x    = '0;
        cmd_ch.pos_y    = '0;
        cmd_ch.radius   = '0;
        for (int q = 0; q < qbb_pkg::QUADS; q++) bin_count[q] = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table
        for (int k = 0; k < $size(dir_plan); k++) begin
            for (int j = 0; j < dir_plan[k].reps; j++) begin
                c.func     = dir_plan[k].func;
                c.shape_id = dir_plan[k].id + j[qbb_pkg::SHAPE_W-1:0];
                c.pos_x    = dir_plan[k].x;
                c.pos_y    = dir_plan[k].y;
                c.radius   = dir_plan[k].r;
                want = '{cand_id: dir_plan[k].w_id, quad_mask: dir_plan[k].w_mask,
                         overflow: dir_plan[k].w_ovf, last: 1'b1};
                send_cmd(c, dir_plan[k].typed, want);
            end
        end

        // Half-size settings: collapsed, widest, narrowest, lopsided, random, flat
        cfg_w = '{0, 32767, 1, 32767, 0, 1600};
        cfg_h = '{0, 32767, 1, 0, 0, 0};
        cfg_w[4] = $urandom_range(1, 32767);
        cfg_h[4] = $urandom_range(1, 32767);
        cfg_h[5] = $urandom_range(1, 400);

        // Random phases: mostly inserts and retrieves of live ids
        for (int p = 0; p < PHASES; p++) begin
            set_field(cfg_w[p], cfg_h[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 62)      c.func = qbb_pkg::FUNC_INSERT;
                else if (pick < 93) c.func = qbb_pkg::FUNC_RETRIEVE;
                else if (pick < 97) c.func = qbb_pkg::FUNC_CLEAR;
                else                c.func = FUNC_SPARE;
                if (recent_ids.size() > 0 &&
                    ((c.func == qbb_pkg::FUNC_INSERT && $urandom_range(0, 1) == 0) ||
                     (c.func == qbb_pkg::FUNC_RETRIEVE && $urandom_range(0, 4) != 0)))
                    c.shape_id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
                else
                    c.shape_id = qbb_pkg::SHAPE_W'($urandom_range(0, 255));
                hw = pick_coord(half_w);
                hh = pick_coord(half_h);
                c.pos_x = hw[qbb_pkg::POS_W-1:0];
                c.pos_y = hh[qbb_pkg::POS_W-1:0];
                rmax = ((half_w > half_h) ? half_w : half_h) / 8 + 2;
                pick = $urandom_range(0, 9);
                if (pick < 2)      c.radius = '0;
                else if (pick < 7) c.radius = qbb_pkg::RADIUS_W'($urandom_range(0, rmax));
                else               c.radius = qbb_pkg::RADIUS_W'($urandom_range(0, 16383));
                if (c.func == qbb_pkg::FUNC_INSERT) begin
                    recent_ids.insert(recent_ids.size(), c.shape_id);
                    if (recent_ids.size() > RECENT_DEPTH) void'(recent_ids.pop_front());
                end
                send_cmd(c, 1'b0, want);
            end
        end

        // Drain and settle
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (expected_cands.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d commands under %0d half-size settings.", cmds_sent, settings_used);
        $display("Scored %0d result transfers, %0d of them flagging a full quadrant.",
                 cands_checked, overflows_seen);
        if (fail_count == 0) begin
            $display("quadrant_broadphase_binner regression: pass");
        end else begin
            $display("quadrant_broadphase_binner regression: fail");
        end
        $finish;
    end

endmodule
